/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros shared by the tone synth modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/bpts_pkg.sv */
// ---------------------------------------------------------------------------
// bpts_pkg
// shared widths, codes and item types of the beep pattern tone synth
// ---------------------------------------------------------------------------
`default_nettype none

package bpts_pkg;

    // field widths
    localparam int unsigned STEP_W      = 31;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned SEG_W       = 3;
    localparam int unsigned PAT_W       = 2;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 31;
    localparam int unsigned QUEUE_DEPTH = 4;

    // pattern codes
    localparam logic [PAT_W-1:0] PAT_CHIRP    = 2'd0;
    localparam logic [PAT_W-1:0] PAT_INDICATE = 2'd1;
    localparam logic [PAT_W-1:0] PAT_ERROR    = 2'd2;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ERROR_STEP    = 3'd0,
        REG_INDICATE_STEP = 3'd1,
        REG_CHIRP_STEP    = 3'd2,
        REG_VOLUME_GAIN   = 3'd3,
        REG_TONE_LENGTH   = 3'd4,
        REG_GAP_LENGTH    = 3'd5
    } reg_index_t;

    // register reset values
    localparam logic [STEP_W-1:0] RST_ERROR_STEP    = 31'd39370534;
    localparam logic [STEP_W-1:0] RST_INDICATE_STEP = 31'd78741067;
    localparam logic [STEP_W-1:0] RST_CHIRP_STEP    = 31'd93639233;
    localparam logic [GAIN_W-1:0] RST_VOLUME_GAIN   = 16'd13107;
    localparam logic [LEN_W-1:0]  RST_TONE_LENGTH   = 16'd4800;
    localparam logic [LEN_W-1:0]  RST_GAP_LENGTH    = 16'd9600;

    // configuration register file contents
    typedef struct packed {
        logic [STEP_W-1:0] error_step;
        logic [STEP_W-1:0] indicate_step;
        logic [STEP_W-1:0] chirp_step;
        logic [GAIN_W-1:0] gain;
        logic [LEN_W-1:0]  tone_len;
        logic [LEN_W-1:0]  gap_len;
    } cfg_t;

    // one sample job from sequencer to datapath
    typedef struct packed {
        logic               tone;
        logic               last;
        logic [LEN_W-1:0]   env;
        logic [PHASE_W-1:0] phase;
    } job_t;

endpackage

`default_nettype wire

/* sv/beep_pattern_tone_synth.sv */
// tick jobs pass the queue, then the idx, rom, p1, a4, q5, q6 and output sample registers
// throughput: one item per cycle while the job queue has room; the datapath is fully pipelined and stalls as a whole
// a start item gives no result; ticks while idle give none
// a 4-entry job queue lets the sequencer keep taking items while the output is stalled
// reset (rst_n low, asynchronous) leaves the block idle with registers at default values
// the sine table is a constant rom, so no clearing pass follows reset
// ---------------------------------------------------------------------------
// beep_pattern_tone_synth
// beep pattern generator: sequencer, job queue and sine/envelope datapath
// ---------------------------------------------------------------------------
`default_nettype none

module beep_pattern_tone_synth #(
    parameter int unsigned SINE_ENTRIES = 1024,
    parameter int unsigned RAMP_SAMPLES = 200
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [1:0] pattern
    input  logic                            s_axis_tuser,  // [0] kind
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // [15:0] sample
    output logic                            m_axis_tlast,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [bpts_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bpts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bpts_pkg::*;

    cfg_t cfg_reg;
    logic q_ready, push, q_valid, pop;
    job_t push_job, head_job;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.error_step    <= RST_ERROR_STEP;
            cfg_reg.indicate_step <= RST_INDICATE_STEP;
            cfg_reg.chirp_step    <= RST_CHIRP_STEP;
            cfg_reg.gain          <= RST_VOLUME_GAIN;
            cfg_reg.tone_len      <= RST_TONE_LENGTH;
            cfg_reg.gap_len       <= RST_GAP_LENGTH;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_addr))
                REG_ERROR_STEP:    cfg_reg.error_step    <= cfg_wdata[STEP_W-1:0];
                REG_INDICATE_STEP: cfg_reg.indicate_step <= cfg_wdata[STEP_W-1:0];
                REG_CHIRP_STEP:    cfg_reg.chirp_step    <= cfg_wdata[STEP_W-1:0];
                REG_VOLUME_GAIN:   cfg_reg.gain          <= cfg_wdata[GAIN_W-1:0];
                REG_TONE_LENGTH:   cfg_reg.tone_len      <= cfg_wdata[LEN_W-1:0];
                REG_GAP_LENGTH:    cfg_reg.gap_len       <= cfg_wdata[LEN_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // pattern sequencer
    bpts_front #(
        .RAMP_SAMPLES (RAMP_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_pattern (s_axis_tdata[PAT_W-1:0]),
        .cfg        (cfg_reg),
        .q_ready    (q_ready),
        .push       (push),
        .job        (push_job)
    );

    // job queue
    bpts_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_job    (push_job),
        .in_ready  (q_ready),
        .pop       (pop),
        .out_valid (q_valid),
        .out_job   (head_job)
    );

    // sample datapath
    bpts_back #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .RAMP_SAMPLES (RAMP_SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_job     (head_job),
        .pop        (pop),
        .gain       (cfg_reg.gain),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sv/bpts_front.sv */
// ---------------------------------------------------------------------------
// bpts_front
// pattern sequencer: takes start and tick items, walks the tone and gap
// segments and emits one sample job per tick while a pattern plays
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpts_front #(
    parameter int unsigned RAMP_SAMPLES = 200
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_kind,
    input  logic [bpts_pkg::PAT_W-1:0]   in_pattern,
    input  bpts_pkg::cfg_t               cfg,
    input  logic                         q_ready,
    output logic                         push,
    output bpts_pkg::job_t               job
);
    import bpts_pkg::*;

    localparam int unsigned MAX_SEGMENTS = 5;
    localparam logic [LEN_W-1:0] RAMP_C = LEN_W'(RAMP_SAMPLES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PLAY = 2'b10
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [PAT_W-1:0]   pat_reg, pat_next;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic               accept;
    logic               tone_zero, gap_zero;
    logic [SEG_W-1:0]   cur_cnt, start_cnt, start_seg, after_seg;
    logic [LEN_W-1:0]   seg_len, rest, env_lim, env;
    logic               seg_end, last_flag;
    logic [STEP_W-1:0]  cur_step;

    // segments in a pattern
    function automatic logic [SEG_W-1:0] seg_count(input logic [PAT_W-1:0] pat);
        case (pat)
            PAT_ERROR:    return 3'd5;
            PAT_INDICATE: return 3'd3;
            default:      return 3'd1;
        endcase
    endfunction

    // first segment at or after seg that has a nonzero length
    function automatic logic [SEG_W-1:0] skip_empty(
        input logic [SEG_W-1:0] seg,
        input logic [SEG_W-1:0] cnt,
        input logic             tz,
        input logic             gz
    );
        logic [SEG_W-1:0] s;
        s = seg;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (s < cnt && (s[0] ? gz : tz)) begin
                s = s + 3'd1;
            end
        end
        return s;
    endfunction

    assign in_ready  = q_ready;
    assign accept    = in_valid && in_ready;
    assign tone_zero = (cfg.tone_len == '0);
    assign gap_zero  = (cfg.gap_len == '0);

    // segment bookkeeping
    always_comb
    begin
        cur_cnt   = seg_count(pat_reg);
        start_cnt = seg_count(in_pattern);
        start_seg = skip_empty('0, start_cnt, tone_zero, gap_zero);
        after_seg = skip_empty(seg_reg + 3'd1, cur_cnt, tone_zero, gap_zero);
        seg_len   = seg_reg[0] ? cfg.gap_len : cfg.tone_len;
        seg_end   = ({1'b0, pos_reg} + 17'd1) >= {1'b0, seg_len};
        case (pat_reg)
            PAT_ERROR:    cur_step = cfg.error_step;
            PAT_INDICATE: cur_step = cfg.indicate_step;
            default:      cur_step = cfg.chirp_step;
        endcase
    end

    // trapezoid envelope numerator
    always_comb
    begin
        rest    = (pos_reg < cfg.tone_len) ? (cfg.tone_len - pos_reg) : '0;
        env_lim = (pos_reg < rest) ? pos_reg : rest;
        env     = (env_lim < RAMP_C) ? env_lim : RAMP_C;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        pat_next   = pat_reg;
        seg_next   = seg_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        push       = 1'b0;
        last_flag  = 1'b0;
        if (accept) begin
            if (in_kind == KIND_START) begin
                pat_next   = in_pattern;
                seg_next   = start_seg;
                pos_next   = '0;
                phase_next = '0;
                state_next = (start_seg < start_cnt) ? ST_PLAY : ST_IDLE;
            end else if (state_reg == ST_PLAY) begin
                push = 1'b1;
                if (seg_end) begin
                    pos_next   = '0;
                    phase_next = '0;
                    if (after_seg >= cur_cnt) begin
                        last_flag  = 1'b1;
                        state_next = ST_IDLE;
                        seg_next   = '0;
                    end else begin
                        seg_next = after_seg;
                    end
                end else begin
                    pos_next   = pos_reg + 16'd1;
                    phase_next = phase_reg + {1'b0, cur_step};
                end
            end
        end
    end

    // job payload
    always_comb
    begin
        job.tone  = !seg_reg[0];
        job.last  = last_flag;
        job.env   = env;
        job.phase = phase_reg;
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            pat_reg   <= PAT_CHIRP;
            seg_reg   <= '0;
            pos_reg   <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            pat_reg   <= pat_next;
            seg_reg   <= seg_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    `ASSERT_IMPL(a_seg_in_pattern, state_reg == ST_PLAY, seg_reg < cur_cnt)
    `ASSERT_NEXT(a_last_ends_pattern, push && job.last, state_reg == ST_IDLE)

endmodule

`default_nettype wire

/* sv/bpts_fifo.sv */
// ---------------------------------------------------------------------------
// bpts_fifo
// short job queue between the sequencer and the sample datapath
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpts_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bpts_pkg::job_t in_job,
    output logic           in_ready,
    input  logic           pop,
    output logic           out_valid,
    output bpts_pkg::job_t out_job
);
    import bpts_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign in_ready  = (count_reg != DEPTH_C);
    assign out_valid = (count_reg != '0);
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;
    assign out_job   = mem[rd_ptr_reg];

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

/* sv/bpts_back.sv */
// ---------------------------------------------------------------------------
// bpts_back
// sample datapath: phase to table index, sine rom read, gain and envelope
// multiplies, division by the ramp length, output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpts_back #(
    parameter int unsigned SINE_ENTRIES = 1024,
    parameter int unsigned RAMP_SAMPLES = 200
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  bpts_pkg::job_t                in_job,
    output logic                          pop,
    input  logic [bpts_pkg::GAIN_W-1:0]   gain,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpts_pkg::SAMPLE_W-1:0] out_sample,
    output logic                          out_last
);
    import bpts_pkg::*;

    // widths of the datapath
    localparam int unsigned IW    = $clog2(SINE_ENTRIES);
    localparam int unsigned EW    = $clog2(RAMP_SAMPLES + 1);
    localparam int unsigned MAG_W = SAMPLE_W - 1;
    localparam int unsigned P1_W  = MAG_W + GAIN_W;
    localparam int unsigned P2_W  = P1_W + EW;
    localparam int unsigned AW    = P2_W - GAIN_W;
    localparam int unsigned QW    = SAMPLE_W;
    localparam int unsigned MW    = GAIN_W + 1;

    // constants of the datapath
    localparam logic [IW:0]   ENTRIES_C = (IW + 1)'(SINE_ENTRIES);
    localparam logic [EW-1:0] RAMP_C    = EW'(RAMP_SAMPLES);
    localparam logic [MW-1:0] RECIP     = MW'((64'd1 << AW) / RAMP_SAMPLES);
    localparam logic [AW:0]   RAMP_W    = (AW + 1)'(RAMP_SAMPLES);
    localparam logic [AW:0]   RAMP_2X   = (AW + 1)'(2 * RAMP_SAMPLES);

    // constants of the table build
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam longint unsigned ENTRIES_L = longint'(SINE_ENTRIES);
    localparam longint unsigned HALF_DIV  = 2 * ENTRIES_L;

    // sine of a quarter wave angle, Q1.15, Taylor series in Q30
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input longint unsigned m);
        longint unsigned x, x2, t;
        longint          s;
        x  = (PI_Q30 * m) / HALF_DIV;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t  = ((t * x2) >> 30) / 6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 156;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 210;
        s  = s - longint'(t);
        if (s < 0) begin
            s = 0;
        end
        s = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        return SAMPLE_W'(s);
    endfunction

    // full wave table entry from quarter wave symmetry
    function automatic logic [SAMPLE_W-1:0] sine_entry(input longint unsigned k);
        longint unsigned r, q, rem, m;
        logic [SAMPLE_W-1:0] v;
        r   = 4 * k;
        q   = r / ENTRIES_L;
        rem = r % ENTRIES_L;
        m   = q[0] ? (ENTRIES_L - rem) : rem;
        v   = quarter_sine(m);
        return (q >= 2) ? -v : v;
    endfunction

    typedef struct packed {
        logic tone;
        logic last;
    } side_t;

    // sine rom contents
    logic signed [SAMPLE_W-1:0] sine_rom [SINE_ENTRIES];
    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(longint'(k));
        assign sine_rom[k] = ENTRY;
    end

    logic                       adv;
    logic [6:1]                 v_reg;
    side_t                      side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    logic [EW-1:0]              env1_reg, env2_reg, env3_reg;
    logic [IW-1:0]              idx_reg;
    logic signed [SAMPLE_W-1:0] rom_reg;
    logic                       neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [P1_W-1:0]            p1_reg;
    logic [AW-1:0]              a4_reg, a5_reg, a6_reg;
    logic [QW-1:0]              q5_reg, q6_reg;
    logic [AW:0]                qr_reg;
    logic                       out_valid_reg, out_last_reg;
    logic [SAMPLE_W-1:0]        out_sample_reg;

    logic [32+IW:0]             idx_prod;
    logic [SAMPLE_W-1:0]        mag_full;
    logic [MAG_W-1:0]           mag;
    logic [P1_W-1:0]            p1;
    logic [P2_W-1:0]            p2;
    logic [AW+MW-1:0]           recip_prod;
    logic [AW:0]                rem_w;
    logic [QW-1:0]              quo;
    logic [SAMPLE_W-1:0]        sample_val;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && in_valid;

    // arithmetic between the stages
    always_comb
    begin
        idx_prod   = in_job.phase * ENTRIES_C;
        mag_full   = rom_reg[SAMPLE_W-1] ? SAMPLE_W'(-rom_reg) : SAMPLE_W'(rom_reg);
        mag        = mag_full[MAG_W-1:0];
        p1         = mag * gain;
        p2         = p1_reg * env3_reg;
        recip_prod = a4_reg * RECIP;
        rem_w      = {1'b0, a6_reg} - qr_reg;
        quo        = q6_reg + ((rem_w >= RAMP_W) ? QW'(1) : QW'(0));
        if (!side6_reg.tone) begin
            sample_val = '0;
        end else if (neg6_reg) begin
            sample_val = -quo;
        end else begin
            sample_val = quo;
        end
    end

    // pipeline valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg         <= {v_reg[5:1], in_valid};
            out_valid_reg <= v_reg[6];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv) begin
            // table index and envelope
            idx_reg   <= idx_prod[32 +: IW];
            env1_reg  <= in_job.env[EW-1:0];
            side1_reg <= '{tone: in_job.tone, last: in_job.last};
            // rom read
            rom_reg   <= sine_rom[idx_reg];
            env2_reg  <= env1_reg;
            side2_reg <= side1_reg;
            // magnitude times gain
            p1_reg    <= p1;
            neg3_reg  <= rom_reg[SAMPLE_W-1];
            env3_reg  <= env2_reg;
            side3_reg <= side2_reg;
            // times envelope, drop the Q0.16 fraction
            a4_reg    <= p2[P2_W-1:GAIN_W];
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;
            // reciprocal estimate of the ramp division
            q5_reg    <= recip_prod[AW +: QW];
            a5_reg    <= a4_reg;
            neg5_reg  <= neg4_reg;
            side5_reg <= side4_reg;
            // back multiply for the correction
            qr_reg    <= (AW + 1)'(q5_reg) * (AW + 1)'(RAMP_C);
            q6_reg    <= q5_reg;
            a6_reg    <= a5_reg;
            neg6_reg  <= neg5_reg;
            side6_reg <= side5_reg;
            // corrected quotient, sign and gap mute
            out_sample_reg <= sample_val;
            out_last_reg   <= side6_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;

    `ASSERT_IMPL(a_recip_error, v_reg[6], rem_w < RAMP_2X)

endmodule

`default_nettype wire
